// ===== hdl/sss_pkg.sv =====
`timescale 1ns / 1ps
// Package for the SSS chip generator: sequence constants, cell bit struct,
// and the cell group to (m0, m1) lookup table. No dependencies.
package sss_pkg;

    localparam int SEQ_LEN    = 31;
    localparam int SEQ_RUN    = 26;
    localparam int GROUP_DIV  = 30;
    localparam int SHIFT_MOD  = 8;
    localparam int C1_OFFSET  = 3;
    localparam int CHIP_COUNT = 62;
    localparam int GROUPS     = 256;

    // Bits held by one cell: the six shifted sequences at one position.
    typedef struct packed {
        logic s0;
        logic s1;
        logic c0;
        logic c1;
        logic za;
        logic zb;
    } t_chip_bits;

    typedef logic [SEQ_LEN-1:0] t_seq;
    typedef logic [9:0] t_m_tab [0:GROUPS-1];

    // Length-31 m-sequence from seed 00001; tap bit i selects x(k+i).
    function automatic t_seq make_mseq(input logic [4:0] taps);
        t_seq seq;
        logic v;
        seq = '0;
        seq[4] = 1'b1;
        for (int k = 0; k < SEQ_RUN; k++) begin
            v = 1'b0;
            for (int i = 0; i < 5; i++) begin
                if (taps[i]) v = v ^ seq[k + i];
            end
            seq[k + 5] = v;
        end
        return seq;
    endfunction

    localparam t_seq S_SEQ = make_mseq(5'h05);
    localparam t_seq C_SEQ = make_mseq(5'h09);
    localparam t_seq Z_SEQ = make_mseq(5'h17);

    // {m1, m0} for every 8-bit group value, built at elaboration.
    function automatic t_m_tab build_m_tab();
        t_m_tab tab;
        int qp, q, mp, m0, m1;
        for (int g = 0; g < GROUPS; g++) begin
            qp = g / GROUP_DIV;
            q  = (g + (qp * (qp + 1)) / 2) / GROUP_DIV;
            mp = g + (q * (q + 1)) / 2;
            m0 = mp % SEQ_LEN;
            m1 = (m0 + mp / SEQ_LEN + 1) % SEQ_LEN;
            tab[g] = {5'(m1), 5'(m0)};
        end
        return tab;
    endfunction

    localparam t_m_tab M_TAB = build_m_tab();

    // Pick seq[idx mod 31] for idx below 62.
    function automatic logic pick_mod(input t_seq seq, input logic [5:0] idx);
        logic [5:0] sel;
        sel = (idx >= 6'(SEQ_LEN)) ? idx - 6'(SEQ_LEN) : idx;
        return seq[sel[4:0]];
    endfunction

endpackage

// ===== hdl/sss_cell.sv =====
`timescale 1ns / 1ps
// One cell of the rotating chain: holds six sequence bits at one position.
// Depends on sss_pkg.
module sss_cell (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_shift,
    input  sss_pkg::t_chip_bits i_load_bits,
    input  sss_pkg::t_chip_bits i_next_bits,
    output sss_pkg::t_chip_bits o_bits
);
    import sss_pkg::*;

    t_chip_bits r_bits;
    t_chip_bits n_bits;

    always_comb begin
        n_bits = r_bits;
        if (i_load) n_bits = i_load_bits;
        else if (i_shift) n_bits = i_next_bits;
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_bits = r_bits;

endmodule

// ===== hdl/sss_sequence_generator_unit.sv =====
`timescale 1ns / 1ps
// SSS chip generator top level. Depends on sss_pkg and sss_cell.
// The accepted request is held in the pending register, then loaded into the chain;
// chips leave through the output register, one chip per cycle while i_ready allows,
// from the 31-cell rotating chain which emits two chips per position.
// Reset: synchronous active-low i_rst_n clears pending, chain and output valids.
module sss_sequence_generator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_cell_group,
    input  logic [1:0] i_sector_id,
    // chip channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_chip_index,
    output logic       o_chip_sub0,
    output logic       o_chip_sub5,
    output logic       o_last_chip
);
    import sss_pkg::*;

    // Pending request: m0/m1 from the lookup table, registered at accept.
    logic       r_p_vld;
    logic [4:0] r_p_m0;
    logic [4:0] r_p_m1;
    logic [1:0] r_p_n2;

    // Chain control: position counter and even/odd chip phase.
    logic       r_active;
    logic [4:0] r_n;
    logic       r_phase;

    // Output register
    logic       r_o_vld;
    logic [5:0] r_o_idx;
    logic       r_o_sub0;
    logic       r_o_sub5;
    logic       r_o_last;

    logic       in_acc;
    logic       adv;
    logic       last;
    logic       load;
    logic       shift;
    logic [9:0] m_pair;

    t_chip_bits cell_bits [SEQ_LEN];
    t_chip_bits load_bits [SEQ_LEN];
    t_chip_bits head;

    assign m_pair = M_TAB[i_cell_group];

    // Chain advances one chip whenever the output register can take it.
    assign adv   = r_active && (!r_o_vld || i_ready);
    assign last  = (r_n == 5'(SEQ_LEN - 1)) && r_phase;
    assign load  = r_p_vld && (!r_active || (adv && last));
    assign shift = adv && r_phase;
    assign o_ready = !r_p_vld || load;
    assign in_acc  = i_valid && o_ready;

    // Each cell k loads the sequences rotated so that cell 0 holds index n.
    for (genvar k = 0; k < SEQ_LEN; k++) begin : g_cell
        always_comb begin
            load_bits[k].s0 = pick_mod(S_SEQ, 6'(k) + {1'b0, r_p_m0});
            load_bits[k].s1 = pick_mod(S_SEQ, 6'(k) + {1'b0, r_p_m1});
            load_bits[k].c0 = pick_mod(C_SEQ, 6'(k) + {4'd0, r_p_n2});
            load_bits[k].c1 = pick_mod(C_SEQ, 6'(k) + {4'd0, r_p_n2} + 6'(C1_OFFSET));
            load_bits[k].za = pick_mod(Z_SEQ, 6'(k) + {3'd0, r_p_m0[2:0]});
            load_bits[k].zb = pick_mod(Z_SEQ, 6'(k) + {3'd0, r_p_m1[2:0]});
        end

        sss_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (load),
            .i_shift     (shift),
            .i_load_bits (load_bits[k]),
            .i_next_bits (cell_bits[(k + 1) % SEQ_LEN]),
            .o_bits      (cell_bits[k])
        );
    end

    assign head = cell_bits[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_active <= 1'b0;
            r_n      <= '0;
            r_phase  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (in_acc) r_p_vld <= 1'b1;
            else if (load) r_p_vld <= 1'b0;

            if (load) begin
                r_active <= 1'b1;
                r_n      <= '0;
                r_phase  <= 1'b0;
            end else if (adv) begin
                r_phase <= !r_phase;
                if (r_phase) r_n <= r_n + 5'd1;
                if (last) r_active <= 1'b0;
            end

            if (adv) r_o_vld <= 1'b1;
            else if (i_ready) r_o_vld <= 1'b0;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p_m0 <= m_pair[4:0];
            r_p_m1 <= m_pair[9:5];
            r_p_n2 <= i_sector_id;
        end
        if (adv) begin
            r_o_idx  <= {r_n, r_phase};
            r_o_last <= last;
            if (!r_phase) begin
                // even chip
                r_o_sub0 <= head.s0 ^ head.c0;
                r_o_sub5 <= head.s1 ^ head.c0;
            end else begin
                // odd chip: swapped s, c1 in place of c0, and z scrambling
                r_o_sub0 <= head.s1 ^ head.c1 ^ head.za;
                r_o_sub5 <= head.s0 ^ head.c1 ^ head.zb;
            end
        end
    end

    assign o_valid      = r_o_vld;
    assign o_chip_index = r_o_idx;
    assign o_chip_sub0  = r_o_sub0;
    assign o_chip_sub5  = r_o_sub5;
    assign o_last_chip  = r_o_last;

endmodule

// ===== sim/sss_chip_checker.sv =====
`timescale 1ns / 1ps
// Chip stream checker for the SSS generator: predicts the 62 chips of each
// accepted cell request and compares them with the chip channel. Uses sss_pkg.
module sss_chip_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [7:0] i_cell_group,
    input  logic [1:0] i_sector_id,
    input  logic       i_chip_valid,
    input  logic       i_chip_ready,
    input  logic [5:0] i_chip_index,
    input  logic       i_chip_sub0,
    input  logic       i_chip_sub5,
    input  logic       i_last_chip,
    output int         o_fail_count,
    output int         o_chips_due,
    output int         o_chips_seen
);
    import sss_pkg::*;

    // Feedback taps: s = x^2+1, c = x^3+1, z = x^4+x^2+x+1
    localparam logic [4:0] S_TAPS = 5'h05;
    localparam logic [4:0] C_TAPS = 5'h09;
    localparam logic [4:0] Z_TAPS = 5'h17;

    typedef struct packed {
        logic [5:0] idx;
        logic       sub0;
        logic       sub5;
        logic       last;
    } t_chip;

    t_chip chips_due_q[$];
    int    fail_cnt = 0;
    int    seen_cnt = 0;
    t_chip got;
    t_chip want;

    function automatic logic [SEQ_LEN-1:0] lfsr_seq(input logic [4:0] taps);
        logic [SEQ_LEN-1:0] bits;
        bits = '0;
        bits[4] = 1'b1;
        for (int k = 0; k < SEQ_RUN; k++) bits[k+5] = ^(bits[k +: 5] & taps);
        return bits;
    endfunction

    // Expand one cell request into its 62 expected chips.
    task automatic queue_chips(input logic [7:0] grp, input logic [1:0] sec);
        int qp, q, mp, m0, m1, za_sh, zb_sh, g, ns;
        logic [SEQ_LEN-1:0] s_b, c_b, z_b;
        t_chip ev, od;
        s_b = lfsr_seq(S_TAPS);
        c_b = lfsr_seq(C_TAPS);
        z_b = lfsr_seq(Z_TAPS);
        g  = int'(grp);
        ns = int'(sec);
        qp = g / GROUP_DIV;
        q  = (g + (qp * (qp + 1)) / 2) / GROUP_DIV;
        mp = g + (q * (q + 1)) / 2;
        m0 = mp % SEQ_LEN;
        m1 = (m0 + mp / SEQ_LEN + 1) % SEQ_LEN;
        za_sh = m0 % SHIFT_MOD;
        zb_sh = m1 % SHIFT_MOD;
        for (int n = 0; n < SEQ_LEN; n++) begin
            ev.idx  = 6'(2 * n);
            ev.sub0 = s_b[(n + m0) % SEQ_LEN] ^ c_b[(n + ns) % SEQ_LEN];
            ev.sub5 = s_b[(n + m1) % SEQ_LEN] ^ c_b[(n + ns) % SEQ_LEN];
            ev.last = 1'b0;
            od.idx  = 6'(2 * n + 1);
            od.sub0 = s_b[(n + m1) % SEQ_LEN] ^ c_b[(n + ns + C1_OFFSET) % SEQ_LEN]
                      ^ z_b[(n + za_sh) % SEQ_LEN];
            od.sub5 = s_b[(n + m0) % SEQ_LEN] ^ c_b[(n + ns + C1_OFFSET) % SEQ_LEN]
                      ^ z_b[(n + zb_sh) % SEQ_LEN];
            od.last = (2 * n + 1 == CHIP_COUNT - 1);
            chips_due_q.push_back(ev);
            chips_due_q.push_back(od);
        end
    endtask

    task automatic flag_field(input string field, input int exp_v, input int act_v);
        fail_cnt++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d",
                 $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chips_due_q.delete();
        end else begin
            // chip side first: a request taken on this edge cannot yield a chip yet
            if (i_chip_valid && i_chip_ready) begin
                got = '{i_chip_index, i_chip_sub0, i_chip_sub5, i_last_chip};
                seen_cnt++;
                if (chips_due_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t ns: unexpected chip, expected none, got index %0d",
                             $time, got.idx);
                end else begin
                    want = chips_due_q.pop_front();
                    if (got.idx != want.idx)
                        flag_field("chip_index", int'(want.idx), int'(got.idx));
                    if (got.sub0 != want.sub0)
                        flag_field("chip_sub0", int'(want.sub0), int'(got.sub0));
                    if (got.sub5 != want.sub5)
                        flag_field("chip_sub5", int'(want.sub5), int'(got.sub5));
                    if (got.last != want.last)
                        flag_field("last_chip", int'(want.last), int'(got.last));
                end
            end
            if (i_req_valid && i_req_ready) queue_chips(i_cell_group, i_sector_id);
        end
        o_fail_count <= fail_cnt;
        o_chips_due  <= chips_due_q.size();
        o_chips_seen <= seen_cnt;
    end

endmodule

// ===== sim/sss_sequence_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for sss_sequence_generator_unit: drives cell requests and
// chip back-pressure, gives the verdict. Depends on sss_sequence_generator_unit and sss_chip_checker.
module sss_sequence_generator_unit_tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_cell_group = '0;
    logic [1:0] i_sector_id = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [5:0] o_chip_index;
    logic       o_chip_sub0;
    logic       o_chip_sub5;
    logic       o_last_chip;

    int fail_count;
    int chips_due;
    int chips_seen;
    int cells_sent = 0;

    // Idle rates, percent of cycles / items; changed per phase.
    int sender_idle_pct = 0;
    int rx_stall_pct = 0;

    // Directed groups: zero, all ones, the q' and q boundaries (multiples
    // of 30 and their neighbors), the top standard group and the
    // non-standard range above it.
    localparam int N_DIRECTED = 22;
    localparam logic [7:0] DIR_GROUPS [N_DIRECTED] = '{
        8'd0,   8'd1,   8'd29,  8'd30,  8'd31,  8'd59,  8'd60,  8'd61,
        8'd89,  8'd90,  8'd119, 8'd120, 8'd149, 8'd150, 8'd166, 8'd167,
        8'd168, 8'd170, 8'd200, 8'd231, 8'd254, 8'd255
    };
    localparam int RANDOM_PER_PHASE = 52;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    sss_sequence_generator_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cell_group (i_cell_group),
        .i_sector_id  (i_sector_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_chip_index (o_chip_index),
        .o_chip_sub0  (o_chip_sub0),
        .o_chip_sub5  (o_chip_sub5),
        .o_last_chip  (o_last_chip)
    );

    sss_chip_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_cell_group (i_cell_group),
        .i_sector_id  (i_sector_id),
        .i_chip_valid (o_valid),
        .i_chip_ready (i_ready),
        .i_chip_index (o_chip_index),
        .i_chip_sub0  (o_chip_sub0),
        .i_chip_sub5  (o_chip_sub5),
        .i_last_chip  (o_last_chip),
        .o_fail_count (fail_count),
        .o_chips_due  (chips_due),
        .o_chips_seen (chips_seen)
    );

    // Chip side back-pressure: ready drops on rx_stall_pct of the cycles.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one request; an optional idle gap first so that the next
    // request lands on a random point of the 62-chip burst.
    task automatic send_cell(input logic [7:0] grp, input logic [1:0] sec);
        int gap;
        if ($urandom_range(99) < sender_idle_pct) begin
            gap = $urandom_range(70, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_group <= grp;
        i_sector_id  <= sec;
        do @(posedge i_clk); while (!o_ready);
        cells_sent++;
    endtask

    // Stop offering and hold off until every predicted chip has come out.
    task automatic drain_chips();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chips_due != 0);
    endtask

    initial begin
        logic [7:0] grp;
        logic [1:0] sec;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling: every sector id (3 included) is swept
        // across the boundary groups.
        for (int d = 0; d < N_DIRECTED; d++) begin
            send_cell(DIR_GROUPS[d], 2'(d % 4));
        end
        drain_chips();

        // Random part in four flow-control phases; each phase ends with a
        // full drain so the pipeline is seen empty between them.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin sender_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                // Mostly standard cells; some groups above 167 and sector 3.
                if ($urandom_range(99) < 85) grp = 8'($urandom_range(167));
                else grp = 8'($urandom_range(255, 168));
                if ($urandom_range(99) < 88) sec = 2'($urandom_range(2));
                else sec = 2'd3;
                send_cell(grp, sec);
            end
            drain_chips();
        end

        // Room for any stray chip after the last one.
        rx_stall_pct = 0;
        repeat (20) @(posedge i_clk);

        $display("Covered %0d cell requests (groups 0..255, sectors 0..3), %0d chips checked",
                 cells_sent, chips_seen);
        $display("under no idling, sender gaps, chip stalls and both combined");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d chips still due", chips_due);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sss_pkg.sv
hdl/sss_cell.sv
hdl/sss_sequence_generator_unit.sv
sim/sss_chip_checker.sv
sim/sss_sequence_generator_unit_tb.sv
